// File: rtl/gauss_seidel_poisson_solver_assert.svh
`ifndef GAUSS_SEIDEL_POISSON_SOLVER_ASSERT_SVH
`define GAUSS_SEIDEL_POISSON_SOLVER_ASSERT_SVH
// Assertion helpers; clock and reset are the module's clk and rst_n.
`define GSP_ASSERT_IMPL(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);
`define GSP_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);
`endif

// File: rtl/gsp_pkg.sv
package gsp_pkg;
    localparam int VB = 32;
    localparam logic [1:0] CMD_WRITE_U = 2'd0;
    localparam logic [1:0] CMD_WRITE_F = 2'd1;
    localparam logic [1:0] CMD_SOLVE   = 2'd2;
    localparam logic [1:0] CMD_READ_U  = 2'd3;
    localparam logic [1:0] REG_GRID_SIZE = 2'd0;
    localparam logic [1:0] REG_TOLERANCE = 2'd1;
    localparam logic [1:0] REG_STEP_SQ   = 2'd2;
    localparam logic [1:0] REG_SWEEP_LIM = 2'd3;
    localparam logic KIND_READ  = 1'b0;
    localparam logic KIND_SOLVE = 1'b1;

    typedef struct packed {
        logic [1:0] cmd;
        logic [5:0] row;
        logic [5:0] col;
        logic signed [31:0] value;
    } gsp_in_t;

    typedef struct packed {
        logic kind;
        logic signed [31:0] data;
        logic [15:0] sweeps;
        logic converged;
    } gsp_out_t;

    function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic signed [32:0] s;
        s = 33'(a) + 33'(b);
        if (s > 33'sd2147483647) return 32'sh7fffffff;
        if (s < -33'sd2147483648) return 32'sh80000000;
        return s[31:0];
    endfunction
endpackage

// File: rtl/gsp_update.sv
// Point update: product and partial sum registered, rest combinational.
module gsp_update
    import gsp_pkg::*;
(
    input  logic               clk,
    input  logic        [16:0] step_sq,
    input  logic signed [31:0] f,
    input  logic signed [31:0] un,
    input  logic signed [31:0] us,
    input  logic signed [31:0] uw,
    input  logic signed [31:0] ue,
    input  logic signed [31:0] uo,
    output logic signed [31:0] nv,
    output logic        [32:0] delta
);
    logic [32:0] mag;
    logic [49:0] prod_full;
    logic [49:0] prod_reg;
    logic        fneg_reg;
    logic signed [31:0] s1_reg, s2_reg, old_reg;
    logic signed [31:0] p;
    logic signed [31:0] s;
    logic signed [32:0] dd;

    assign mag = f[31] ? (33'd0 - 33'(f)) : 33'(f);
    assign prod_full = (50'(mag) * 50'(step_sq)) >> 16;

    // saturating adds do not reassociate: accumulate north, south, west, east in order
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_full;
        fneg_reg <= f[31];
        s1_reg   <= sat_add(sat_add(un, us), uw);
        s2_reg   <= ue;
        old_reg  <= uo;
    end

    always_comb
    begin
        if (fneg_reg)
            p = (prod_reg >= 50'h80000000) ? 32'sh80000000 : -$signed(prod_reg[31:0]);
        else
            p = (prod_reg >= 50'h80000000) ? 32'sh7fffffff : $signed(prod_reg[31:0]);
        s = sat_add(s1_reg, s2_reg);
        if (p == 32'sh80000000)
            s = sat_add(sat_add(s, 32'sh7fffffff), 32'sd1);
        else
            s = sat_add(s, -p);
        nv = s / 4;
        dd = 33'(nv) - 33'(old_reg);
        delta = dd[32] ? 33'(-dd) : 33'(dd);
    end
endmodule

// File: rtl/gauss_seidel_poisson_solver.sv
// Channel | fields                  | handshake
// in      | cmd,row,col,value       | in_valid / in_stall
// out     | kind,data,sweeps,conv   | out_valid / out_stall
// Writes land in memory when taken; a read passes the memory read register,
// then ST_RD, then the output register. A solve steps each point through the
// states N, S, W, E, O, C1, C2 and WB: it reads five u words and one f word over
// the single read port of each memory, runs the update pipeline, then writes back.
// Reset clears control, sets config defaults; grid memories undefined until written.
// Input stalls while a result waits or a read or solve is in progress.
module gauss_seidel_poisson_solver
    import gsp_pkg::*;
#(
    parameter int MAX_INTERIOR = 62
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  gsp_in_t     in_item,
    output logic        out_valid,
    input  logic        out_stall,
    output gsp_out_t    out_item,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [30:0] cfg_data
);
    localparam int SIDE = MAX_INTERIOR + 2;
    localparam int AW = $clog2(SIDE * SIDE);
    localparam int NW = $clog2(MAX_INTERIOR + 1);

    localparam logic [3:0] ST_IDLE = 4'd0, ST_RD = 4'd1, ST_N = 4'd2, ST_S = 4'd3,
        ST_W = 4'd4, ST_E = 4'd5, ST_O = 4'd6, ST_C1 = 4'd7, ST_C2 = 4'd8,
        ST_WB = 4'd9, ST_DONE = 4'd10;

    logic [5:0]  grid_size_reg;
    logic [30:0] tol_reg;
    logic [16:0] step_sq_reg;
    logic [15:0] sweep_lim_reg;
    logic [3:0]  state_reg;
    logic [NW-1:0] r_reg, c_reg, n_reg;
    logic [15:0] cnt_reg;
    logic [32:0] worst_reg;
    logic        out_valid_reg;
    gsp_out_t    out_reg;
    logic        rd_oob_reg;

    logic signed [31:0] umem [SIDE*SIDE];
    logic signed [31:0] fmem [SIDE*SIDE];
    logic [AW-1:0] raddr, waddr, center;
    logic        we;
    logic signed [31:0] wdata, udata_reg, fdata_reg;
    logic signed [31:0] un_reg, us_reg, uw_reg, ue_reg, uo_reg;
    logic signed [31:0] nv;
    logic [32:0] delta;

    logic in_acc;
    logic in_range;
    logic [AW-1:0] in_addr;

    assign in_acc = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE) || out_valid_reg;
    assign in_range = (int'(in_item.row) < SIDE) && (int'(in_item.col) < SIDE);
    assign in_addr = AW'(int'(in_item.row) * SIDE + int'(in_item.col));
    assign center = AW'(int'(r_reg) * SIDE + int'(c_reg));

    always_comb
    begin
        case (state_reg)
            ST_IDLE: raddr = in_addr;
            ST_N:    raddr = center - AW'(SIDE);
            ST_S:    raddr = center + AW'(SIDE);
            ST_W:    raddr = center - AW'(1);
            ST_E:    raddr = center + AW'(1);
            default: raddr = center;
        endcase
    end

    // u write port: load items or the solve write-back
    always_comb
    begin
        we = 1'b0;
        waddr = in_addr;
        wdata = in_item.value;
        if (state_reg == ST_WB)
        begin
            we = 1'b1;
            waddr = center;
            wdata = nv;
        end
        else if (in_acc && in_item.cmd == CMD_WRITE_U && in_range)
            we = 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (we)
            umem[waddr] <= wdata;
        if (in_acc && in_item.cmd == CMD_WRITE_F && in_range)
            fmem[in_addr] <= in_item.value;
        udata_reg <= umem[raddr];
        fdata_reg <= fmem[raddr];
    end

    // capture neighbors as each read returns
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_S: un_reg <= udata_reg;
            ST_W: us_reg <= udata_reg;
            ST_E: uw_reg <= udata_reg;
            ST_O: ue_reg <= udata_reg;
            ST_C1: uo_reg <= udata_reg;
            default: ;
        endcase
    end

    gsp_update u_upd (
        .clk(clk), .step_sq(step_sq_reg), .f(fdata_reg),
        .un(un_reg), .us(us_reg), .uw(uw_reg), .ue(ue_reg), .uo(uo_reg),
        .nv(nv), .delta(delta)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_size_reg <= 6'd62;
            tol_reg <= 31'd66;
            step_sq_reg <= 17'd17;
            sweep_lim_reg <= 16'hffff;
            state_reg <= ST_IDLE;
            out_valid_reg <= 1'b0;
            out_reg <= '0;
            r_reg <= '0; c_reg <= '0; n_reg <= '0;
            cnt_reg <= '0; worst_reg <= '0; rd_oob_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_GRID_SIZE: grid_size_reg <= cfg_data[5:0];
                    REG_TOLERANCE: tol_reg <= cfg_data;
                    REG_STEP_SQ:   step_sq_reg <= cfg_data[16:0];
                    REG_SWEEP_LIM: sweep_lim_reg <= cfg_data[15:0];
                    default:       ;
                endcase
            end
            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_acc && in_item.cmd == CMD_READ_U)
                    begin
                        rd_oob_reg <= !in_range;
                        state_reg <= ST_RD;
                    end
                    else if (in_acc && in_item.cmd == CMD_SOLVE)
                    begin
                        if (grid_size_reg == 6'd0)
                            n_reg <= NW'(1);
                        else if (int'(grid_size_reg) > MAX_INTERIOR)
                            n_reg <= NW'(MAX_INTERIOR);
                        else
                            n_reg <= NW'(grid_size_reg);
                        r_reg <= NW'(1); c_reg <= NW'(1);
                        cnt_reg <= '0; worst_reg <= '0;
                        state_reg <= ST_N;
                    end
                end
                ST_RD:
                begin
                    out_reg <= '{kind: KIND_READ, data: rd_oob_reg ? 32'sd0 : udata_reg,
                                 sweeps: 16'd0, converged: 1'b0};
                    out_valid_reg <= 1'b1;
                    state_reg <= ST_IDLE;
                end
                ST_WB:
                begin
                    logic [32:0] w;
                    w = (delta > worst_reg) ? delta : worst_reg;
                    if (c_reg != n_reg)
                    begin
                        c_reg <= c_reg + NW'(1);
                        worst_reg <= w;
                        state_reg <= ST_N;
                    end
                    else if (r_reg != n_reg)
                    begin
                        c_reg <= NW'(1); r_reg <= r_reg + NW'(1);
                        worst_reg <= w;
                        state_reg <= ST_N;
                    end
                    else if (w > 33'(tol_reg) && (cnt_reg + 16'd1) < sweep_lim_reg)
                    begin
                        cnt_reg <= cnt_reg + 16'd1;
                        r_reg <= NW'(1); c_reg <= NW'(1);
                        worst_reg <= '0;
                        state_reg <= ST_N;
                    end
                    else
                    begin
                        out_reg <= '{kind: KIND_SOLVE, data: 32'sd0, sweeps: cnt_reg + 16'd1,
                                     converged: w <= 33'(tol_reg)};
                        worst_reg <= w;
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    out_valid_reg <= 1'b1;
                    state_reg <= ST_IDLE;
                end
                default: state_reg <= state_reg + 4'd1;
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item = out_reg;

    `include "gauss_seidel_poisson_solver_assert.svh"
    `GSP_ASSERT_IMPL(a_busy_stalls, state_reg != ST_IDLE, in_stall, "input taken while busy")
    `GSP_ASSERT_NEXT(a_out_holds, out_valid && out_stall, out_valid, "result dropped under stall")
    `GSP_ASSERT_IMPL(a_wb_in_range, state_reg == ST_WB, r_reg >= NW'(1) && r_reg <= n_reg,
        "row out of range in sweep")
endmodule

// File: test/gsp_checker.sv
module gsp_checker
    import gsp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  gsp_in_t     in_item,
    input  logic        out_valid,
    input  logic        out_stall,
    input  gsp_out_t    out_item,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [30:0] cfg_data,
    output int          fail_count,
    output int          pending
);
    localparam int     EDGE_LEN = 64;
    localparam longint VMAX     = 64'sd2147483647;
    localparam longint VMIN     = -64'sd2147483648;
    localparam longint MAG_CAP  = 64'sd2147483648;

    longint   u_grid [EDGE_LEN*EDGE_LEN];
    longint   f_grid [EDGE_LEN*EDGE_LEN];
    int       n_inner;
    longint   tol_q;
    longint   h2_q;
    int       sweep_cap;
    gsp_out_t awaited_replies [$];

    function automatic longint clip32(longint v);
        if (v > VMAX) return VMAX;
        if (v < VMIN) return VMIN;
        return v;
    endfunction

    // h2 * f on magnitudes, truncated, signed back and saturated
    function automatic longint scaled_rhs(longint fv);
        longint mag, hi, lo, prod;
        mag = (fv < 0) ? -fv : fv;
        hi  = mag >>> 16;
        lo  = mag & 64'hFFFF;
        if (h2_q != 0 && hi > MAG_CAP / h2_q)
            prod = MAG_CAP;
        else
        begin
            prod = hi * h2_q + ((lo * h2_q) >>> 16);
            if (prod > MAG_CAP) prod = MAG_CAP;
        end
        if (fv < 0) return (prod == MAG_CAP) ? VMIN : -prod;
        return (prod >= MAG_CAP) ? VMAX : prod;
    endfunction

    function automatic longint relax_grid(int n);
        longint worst, s, p, nv, d;
        int at;
        worst = 0;
        for (int r = 1; r <= n; r++)
            for (int c = 1; c <= n; c++)
            begin
                at = r * EDGE_LEN + c;
                s  = clip32(u_grid[at-EDGE_LEN] + u_grid[at+EDGE_LEN]);
                s  = clip32(s + u_grid[at-1]);
                s  = clip32(s + u_grid[at+1]);
                p  = scaled_rhs(f_grid[at]);
                if (p == VMIN)
                    s = clip32(clip32(s + VMAX) + 1);
                else
                    s = clip32(s - p);
                nv = s / 4;
                d  = (nv >= u_grid[at]) ? nv - u_grid[at] : u_grid[at] - nv;
                u_grid[at] = nv;
                if (d > worst) worst = d;
            end
        return worst;
    endfunction

    function automatic gsp_out_t solve_reply();
        gsp_out_t rep;
        int n, cap, count;
        longint worst;
        n   = (n_inner < 1) ? 1 : (n_inner > 62 ? 62 : n_inner);
        cap = (sweep_cap == 0) ? 1 : sweep_cap;
        count = 0;
        do
        begin
            worst = relax_grid(n);
            count++;
        end while (worst > tol_q && count < cap);
        rep.kind      = KIND_SOLVE;
        rep.data      = '0;
        rep.sweeps    = count[15:0];
        rep.converged = (worst <= tol_q);
        return rep;
    endfunction

    function automatic void apply_item(gsp_in_t it);
        gsp_out_t rep;
        int at;
        at = int'(it.row) * EDGE_LEN + int'(it.col);
        case (it.cmd)
            CMD_WRITE_U: u_grid[at] = longint'(it.value);
            CMD_WRITE_F: f_grid[at] = longint'(it.value);
            CMD_READ_U:
            begin
                rep.kind      = KIND_READ;
                rep.data      = u_grid[at][31:0];
                rep.sweeps    = '0;
                rep.converged = 1'b0;
                awaited_replies = {awaited_replies, rep};
            end
            default:
            begin
                rep = solve_reply();
                awaited_replies = {awaited_replies, rep};
            end
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        gsp_out_t want;
        if (!rst_n)
        begin
            n_inner   = 62;
            tol_q     = 66;
            h2_q      = 17;
            sweep_cap = 65535;
            awaited_replies.delete();
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            if (cfg_we)
                case (cfg_index)
                    REG_GRID_SIZE: n_inner   = int'(cfg_data[5:0]);
                    REG_TOLERANCE: tol_q     = longint'(cfg_data);
                    REG_STEP_SQ:   h2_q      = longint'(cfg_data[16:0]);
                    default:       sweep_cap = int'(cfg_data[15:0]);
                endcase
            if (in_valid && !in_stall)
                apply_item(in_item);
            if (out_valid && !out_stall)
            begin
                if (awaited_replies.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected reply %p", out_item);
                end
                else
                begin
                    want = awaited_replies.pop_front();
                    if (out_item.kind !== want.kind || out_item.data !== want.data ||
                        out_item.sweeps !== want.sweeps ||
                        out_item.converged !== want.converged)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("reply mismatch: expected %p, got %p", want, out_item);
                    end
                end
            end
            pending = awaited_replies.size();
        end
    end
endmodule

// File: test/tb_top.sv
module tb_top;
    import gsp_pkg::*;

    localparam int RUN_LIMIT = 20000000;
    // random reads and all solves stay inside this corner, which is loaded up front
    localparam int FILL_EDGE = 8;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    gsp_in_t     in_item = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    gsp_out_t    out_item;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = REG_GRID_SIZE;
    logic [30:0] cfg_data = '0;
    int          fail_count;
    int          pending;

    // idling on both sides unless a quiet stretch is running
    bit          jitter = 1'b1;
    // ask the receiver for one long hold-off
    bit          hold_req = 1'b0;
    int          cycle_no = 0;

    gauss_seidel_poisson_solver DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    gsp_checker scoreboard (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_item    (in_item),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_item   (out_item),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Watchdog: give up if the run never drains.
    always @(posedge clk)
    begin
        cycle_no <= cycle_no + 1;
        if (cycle_no > RUN_LIMIT)
        begin
            $display("FAIL gauss_seidel_poisson_solver");
            $finish;
        end
    end

    // Receiver: random stalls, plus one long hold-off so the block backs up
    // and has to stall its own input.
    always @(posedge clk)
    begin
        static int  hold_left = 0;
        static bit  hold_done = 1'b0;
        if (hold_req && !hold_done)
        begin
            hold_left = 400;
            hold_done = 1'b1;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= jitter && ($urandom_range(99) < 18);
    end

    // Offer one item and hold it until the block takes it. Valid stays high
    // between back-to-back items; drop it only for a random gap.
    task automatic send_item(input logic [1:0] cmd, input int row, input int col,
                             input logic [31:0] value);
        if (jitter && $urandom_range(99) < 18)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid      <= 1'b1;
        in_item.cmd   <= cmd;
        in_item.row   <= row[5:0];
        in_item.col   <= col[5:0];
        in_item.value <= value;
        do @(posedge clk); while (in_stall);
    endtask

    // Wait for every reply, then let in-flight writes settle before touching
    // the configuration.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    task automatic load_config(input int n, input int tol, input int h2, input int lim);
        cfg_we <= 1'b1;
        cfg_index <= REG_GRID_SIZE; cfg_data <= 31'(n);   @(posedge clk);
        cfg_index <= REG_TOLERANCE; cfg_data <= 31'(tol); @(posedge clk);
        cfg_index <= REG_STEP_SQ;   cfg_data <= 31'(h2);  @(posedge clk);
        cfg_index <= REG_SWEEP_LIM; cfg_data <= 31'(lim); @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Mostly modest magnitudes so solves can settle; some full-range values.
    function automatic logic [31:0] pick_value();
        if ($urandom_range(99) < 30) return $urandom;
        return 32'($signed($urandom) >>> $urandom_range(8, 20));
    endfunction

    // Writes may land anywhere; reads stay in the loaded corner.
    task automatic random_items(input int count, input int solve_pct, input int read_pct);
        int roll;
        for (int i = 0; i < count; i++)
        begin
            roll = $urandom_range(99);
            if (roll < solve_pct)
                send_item(CMD_SOLVE, $urandom_range(63), $urandom_range(63), $urandom);
            else if (roll < solve_pct + read_pct)
                send_item(CMD_READ_U, $urandom_range(FILL_EDGE - 1),
                          $urandom_range(FILL_EDGE - 1), $urandom);
            else if (roll < solve_pct + read_pct + (100 - solve_pct - read_pct) / 2)
                send_item(CMD_WRITE_U, $urandom_range(63), $urandom_range(63), pick_value());
            else
                send_item(CMD_WRITE_F, $urandom_range(63), $urandom_range(63), pick_value());
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Largest grid the corner holds, one sweep. Fill the corner of u and f
        // first so that nothing later can read an unwritten cell.
        load_config(FILL_EDGE - 2, 0, 65536, 1);
        for (int r = 0; r < FILL_EDGE; r++)
            for (int c = 0; c < FILL_EDGE; c++)
            begin
                send_item(CMD_WRITE_U, r, c, pick_value());
                send_item(CMD_WRITE_F, r, c, pick_value());
            end
        send_item(CMD_SOLVE, 0, 0, 0);
        send_item(CMD_READ_U, 3, 3, 0);
        drain();

        // Directed corners: extreme values, edge addresses, saturating solve.
        load_config(2, 66, 65536, 100);
        send_item(CMD_WRITE_U, 1, 1, 32'h7fffffff);
        send_item(CMD_WRITE_U, 2, 2, 32'h80000000);
        send_item(CMD_WRITE_F, 1, 2, 32'h7fffffff);
        send_item(CMD_WRITE_F, 2, 1, 32'h80000000);
        send_item(CMD_WRITE_U, 63, 63, 32'h80000000);
        send_item(CMD_WRITE_U, 0, 3, 32'h7fffffff);
        send_item(CMD_READ_U, 1, 1, 0);
        send_item(CMD_READ_U, 2, 2, 0);
        send_item(CMD_READ_U, 63, 63, 0);
        send_item(CMD_READ_U, 0, 0, 32'hffffffff);
        send_item(CMD_SOLVE, 63, 63, 32'hffffffff);
        send_item(CMD_READ_U, 1, 1, 0);
        send_item(CMD_READ_U, 2, 1, 0);
        drain();

        // Grid size zero and sweep limit zero both act as one.
        load_config(0, 2147483647, 0, 0);
        send_item(CMD_SOLVE, 0, 0, 0);
        send_item(CMD_READ_U, 1, 1, 0);
        random_items(50, 5, 40);
        drain();

        // Single point, loosest settings: settles within two sweeps.
        load_config(1, 2147483647, 17, 65535);
        random_items(100, 6, 35);
        drain();

        // Step squared just under two, exact tolerance; long quiet stretch.
        jitter = 1'b0;
        load_config(4, 0, 131071, 300);
        random_items(120, 4, 35);
        drain();
        jitter = 1'b1;

        // Read-heavy phase with the long receiver hold-off.
        load_config(6, 1000, 4096, 40);
        hold_req = 1'b1;
        random_items(150, 3, 60);
        drain();

        load_config(3, 66, 17, 200);
        random_items(120, 5, 35);
        drain();

        load_config(5, 500000, 65536, 60);
        random_items(120, 5, 35);
        drain();

        repeat (50) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("PASS gauss_seidel_poisson_solver");
        else
            $display("FAIL gauss_seidel_poisson_solver");
        $finish;
    end
endmodule
